// ===== sv/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window median package
// Shared types for the cell chain and its sequencer.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_SELECT,
        ST_SUM
    } t_state;

    // Operation that every cell of the chain performs.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_AGE,
        CELL_COMPACT,
        CELL_INSERT
    } t_cell_op;

    // Control broadcast to all cells.
    typedef struct packed {
        t_cell_op op;
        logic     restart;
    } t_cell_ctl;

endpackage : swm_pkg
`default_nettype wire

// ===== sv/sliding_window_median_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window median unit
// Keeps the most recent samples sorted in a chain of cells and reports twice
// the window median once the window is full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries i_sample and i_restart.
//   A restart empties the window before the sample is taken. Output channel
//   (o_out_valid / i_out_stall) carries o_median_twice, the sum of the two
//   middle samples (twice the middle one for an odd window). No result is
//   produced while the window is still filling.
//   The window size is written through i_cfg_we / i_cfg_wdata; the user must
//   write it only while idle, which the block does not enforce. Zero acts as
//   one, values above MAX_WINDOW act as MAX_WINDOW. Per item, the cells age
//   at the input transfer, evicted cells are removed, the sample is inserted,
//   the middle cells are selected and summed. A shrunk window evicts all
//   surplus cells, one per cycle, through the compaction shift of the chain.
//   The result sits in an output register, so the next sample is taken
//   while it waits; a stalled receiver holds the unit in its final step
//   only when a newer result is ready to replace the waiting one.
//   Synchronous reset empties the window, drops any pending result and sets
//   the window size to 3.
// ----------------------------------------------------------------------------
module sliding_window_median_unit #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [31:0]  i_sample,
    input  wire         i_restart,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [32:0] o_median_twice,
    input  wire         i_cfg_we,
    input  wire [6:0]   i_cfg_wdata
);
    import swm_pkg::*;

    localparam int N  = MAX_WINDOW;
    localparam int SB = SAMPLE_BITS;
    localparam int AW = (N > 1) ? $clog2(N) : 1;
    localparam int WW = $clog2(N + 1);
    localparam int LV = $clog2(N);
    localparam logic [WW-1:0] MAXW = WW'(N);

    t_state               r_state, n_state;
    logic [6:0]           r_win_size;
    logic signed [SB-1:0] r_sample;
    logic                 r_out_valid;
    logic [32:0]          r_out;

    logic [WW-1:0]        w_win;
    logic [10:0]          w_win_ext;
    t_cell_ctl            w_ctl;
    logic                 w_in_xfer;
    logic                 w_out_free;
    logic                 w_any_dead;
    logic                 w_sel_load;
    logic                 w_out_load;
    logic signed [SB:0]   w_sum;
    logic signed [SB-1:0] w_a;
    logic signed [SB-1:0] w_b;
    logic                 w_emit;

    logic signed [SB-1:0] w_val   [N];
    logic [AW-1:0]        w_age   [N];
    logic [N-1:0]         w_valid;
    logic [N-1:0]         w_dead;
    logic [N-1:0]         w_gt;
    logic [N-1:0]         w_pre   [LV+1];

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_any_dead = |w_dead;

    // Window size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= 7'd3;
        end else if (i_cfg_we) begin
            r_win_size <= i_cfg_wdata;
        end
    end

    // Effective window size, clamped to one through MAX_WINDOW.
    assign w_win_ext = 11'(r_win_size);
    always_comb begin
        if (w_win_ext == 11'd0) begin
            w_win = WW'(1);
        end else if (w_win_ext > 11'(N)) begin
            w_win = MAXW;
        end else begin
            w_win = WW'(w_win_ext);
        end
    end

    // Sample captured at the input transfer, narrowed to the sample width.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sample <= signed'(i_sample[SB-1:0]);
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_in_xfer) n_state = ST_COMPACT;
            ST_COMPACT: if (!w_any_dead) n_state = ST_SELECT;
            ST_SELECT:  n_state = ST_SUM;
            ST_SUM:     if (!w_emit || w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer outputs: cell operation and load strobes.
    always_comb begin
        w_ctl.op      = CELL_HOLD;
        w_ctl.restart = i_restart;
        w_sel_load    = 1'b0;
        w_out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE:    if (w_in_xfer) w_ctl.op = CELL_AGE;
            ST_COMPACT: w_ctl.op = w_any_dead ? CELL_COMPACT : CELL_INSERT;
            ST_SELECT:  w_sel_load = 1'b1;
            ST_SUM:     w_out_load = w_emit && w_out_free;
            default:    w_ctl.op = CELL_HOLD;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // Shift-down enable: set at and above the lowest evicted cell.
    always_comb begin
        w_pre[0] = w_dead;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < N; i++) begin
                if (i >= (1 << l)) begin
                    w_pre[l+1][i] = w_pre[l][i] | w_pre[l][i - (1 << l)];
                end else begin
                    w_pre[l+1][i] = w_pre[l][i];
                end
            end
        end
    end

    // Chain of cells, cell 0 holding the smallest sample.
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic signed [SB-1:0] w_lo_val;
        logic [AW-1:0]        w_lo_age;
        logic                 w_lo_valid;
        logic                 w_lo_gt;
        logic signed [SB-1:0] w_hi_val;
        logic [AW-1:0]        w_hi_age;
        logic                 w_hi_valid;
        logic                 w_hi_dead;

        if (g == 0) begin : g_bottom
            assign w_lo_val   = '0;
            assign w_lo_age   = '0;
            assign w_lo_valid = 1'b0;
            assign w_lo_gt    = 1'b0;
        end else begin : g_lower
            assign w_lo_val   = w_val[g-1];
            assign w_lo_age   = w_age[g-1];
            assign w_lo_valid = w_valid[g-1];
            assign w_lo_gt    = w_gt[g-1];
        end

        if (g == N - 1) begin : g_top
            assign w_hi_val   = '0;
            assign w_hi_age   = '0;
            assign w_hi_valid = 1'b0;
            assign w_hi_dead  = 1'b0;
        end else begin : g_upper
            assign w_hi_val   = w_val[g+1];
            assign w_hi_age   = w_age[g+1];
            assign w_hi_valid = w_valid[g+1];
            assign w_hi_dead  = w_dead[g+1];
        end

        swm_cell #(
            .SB (SB),
            .AW (AW),
            .WW (WW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_sample     (r_sample),
            .i_win        (w_win),
            .i_shift_down (w_pre[LV][g]),
            .i_lo_val     (w_lo_val),
            .i_lo_age     (w_lo_age),
            .i_lo_valid   (w_lo_valid),
            .i_lo_gt      (w_lo_gt),
            .i_hi_val     (w_hi_val),
            .i_hi_age     (w_hi_age),
            .i_hi_valid   (w_hi_valid),
            .i_hi_dead    (w_hi_dead),
            .o_val        (w_val[g]),
            .o_age        (w_age[g]),
            .o_valid      (w_valid[g]),
            .o_dead       (w_dead[g]),
            .o_gt         (w_gt[g])
        );
    end

    // Middle-cell selection.
    swm_select #(
        .N  (N),
        .SB (SB),
        .AW (AW),
        .WW (WW)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_sel_load),
        .i_win   (w_win),
        .i_val   (w_val),
        .i_valid (w_valid),
        .o_a     (w_a),
        .o_b     (w_b),
        .o_emit  (w_emit)
    );

    // Sum of the middle values, one bit wider than a sample.
    assign w_sum = {w_a[SB-1], w_a} + {w_b[SB-1], w_b};

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out <= 33'(w_sum);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_twice = r_out;

endmodule : sliding_window_median_unit
`default_nettype wire

// ===== sv/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window median cell
// Holds one window sample with its age, a valid flag and an eviction mark.
// Ages and marks itself, shifts down over evicted cells, and opens a slot
// for a new sample by shifting up.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SB = 32,
    parameter int AW = 6,
    parameter int WW = 7
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire swm_pkg::t_cell_ctl i_ctl,
    input  wire signed [SB-1:0]  i_sample,
    input  wire [WW-1:0]         i_win,
    input  wire                  i_shift_down,
    input  wire signed [SB-1:0]  i_lo_val,
    input  wire [AW-1:0]         i_lo_age,
    input  wire                  i_lo_valid,
    input  wire                  i_lo_gt,
    input  wire signed [SB-1:0]  i_hi_val,
    input  wire [AW-1:0]         i_hi_age,
    input  wire                  i_hi_valid,
    input  wire                  i_hi_dead,
    output logic signed [SB-1:0] o_val,
    output logic [AW-1:0]        o_age,
    output logic                 o_valid,
    output logic                 o_dead,
    output logic                 o_gt
);
    import swm_pkg::*;

    localparam int CW = (AW + 1 > WW) ? AW + 1 : WW;

    logic signed [SB-1:0] r_val,   n_val;
    logic [AW-1:0]        r_age,   n_age;
    logic                 r_valid, n_valid;
    logic                 r_dead,  n_dead;
    logic [CW-1:0]        w_age_inc;

    // The cell lies above the new sample when it is empty or strictly greater.
    assign o_gt      = !r_valid || (r_val > i_sample);
    assign w_age_inc = CW'(r_age) + CW'(1);

    // Next cell contents for the broadcast operation.
    always_comb begin
        n_val   = r_val;
        n_age   = r_age;
        n_valid = r_valid;
        n_dead  = r_dead;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_AGE: begin
                if (i_ctl.restart) begin
                    n_valid = 1'b0;
                    n_dead  = 1'b0;
                end else begin
                    n_dead = r_valid && (w_age_inc >= CW'(i_win));
                    n_age  = AW'(w_age_inc);
                end
            end
            CELL_COMPACT: begin
                if (i_shift_down) begin
                    n_val   = i_hi_val;
                    n_age   = i_hi_age;
                    n_valid = i_hi_valid;
                    n_dead  = i_hi_dead;
                end
            end
            CELL_INSERT: begin
                if (o_gt && i_lo_gt) begin
                    n_val   = i_lo_val;
                    n_age   = i_lo_age;
                    n_valid = i_lo_valid;
                end else if (o_gt) begin
                    n_val   = i_sample;
                    n_age   = '0;
                    n_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Flags are control state; the sample and age need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dead  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_dead  <= n_dead;
        end
        r_val <= n_val;
        r_age <= n_age;
    end

    assign o_val   = r_val;
    assign o_age   = r_age;
    assign o_valid = r_valid;
    assign o_dead  = r_dead;

endmodule : swm_cell
`default_nettype wire

// ===== sv/swm_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window median selector
// Picks the one or two middle cells of the sorted window and registers them,
// together with a flag telling whether the window is exactly full.
// ----------------------------------------------------------------------------
module swm_select #(
    parameter int N  = 64,
    parameter int SB = 32,
    parameter int AW = 6,
    parameter int WW = 7
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  wire [WW-1:0]         i_win,
    input  wire signed [SB-1:0]  i_val [N],
    input  wire [N-1:0]          i_valid,
    output logic signed [SB-1:0] o_a,
    output logic signed [SB-1:0] o_b,
    output logic                 o_emit
);
    localparam logic [WW-1:0] MAXW = WW'(N);

    logic [AW-1:0]        w_idx_a;
    logic [AW-1:0]        w_idx_b;
    logic [AW-1:0]        w_idx_last;
    logic                 w_full;
    logic signed [SB-1:0] r_a;
    logic signed [SB-1:0] r_b;
    logic                 r_emit;

    // Middle positions: equal for an odd window, adjacent for an even one.
    assign w_idx_b    = AW'(i_win >> 1);
    assign w_idx_a    = i_win[0] ? w_idx_b : w_idx_b - AW'(1);
    assign w_idx_last = AW'(i_win - WW'(1));

    // Valid cells form a prefix, so the window is exactly full when the last is set and the next is not.
    assign w_full = i_valid[w_idx_last] && ((i_win == MAXW) || !i_valid[AW'(i_win)]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (i_load) begin
            r_emit <= w_full;
        end
        if (i_load) begin
            r_a <= i_val[w_idx_a];
            r_b <= i_val[w_idx_b];
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_emit = r_emit;

endmodule : swm_select
`default_nettype wire

// ===== sv/swm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window median checker
// Port-level properties of the median unit, bound to its top level.
// ----------------------------------------------------------------------------
module swm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [32:0] o_median_twice
);

    // Reset leaves the unit empty and ready.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("unit not idle after reset");

    // An input transfer keeps the unit busy through the insert, select and sum steps.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input taken again before the item finished");

    // A new result appears only at the end of an item's processing.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in progress");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_median_twice))
        else $error("stalled result changed or dropped");

endmodule : swm_checker

bind sliding_window_median_unit swm_checker u_swm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_median_twice (o_median_twice)
);
`default_nettype wire
